FILE: rtl/ste_pkg.sv
// Package with shared types and constants for the surface temperature Euler step.
package ste_pkg;

  localparam int unsigned TempW   = 18;
  localparam int unsigned FracW   = 16;
  localparam int unsigned CapW    = 24;
  localparam int unsigned DtW     = 16;
  localparam int unsigned DivBits = 20;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [TempW-1:0] OneKelvin = 18'd64;
  localparam logic [TempW-1:0] TempMax   = 18'd262143;
  localparam logic [DtW-1:0]   DtMax     = 16'd40960;
  localparam logic [31:0]      SigmaQ56  = 32'd4085935379;
  localparam logic [DivBits-1:0] QuoMax  = 20'd524286;

  localparam logic [1:0] RegTimeStep = 2'd0;
  localparam logic [1:0] RegAirTemp  = 2'd1;
  localparam logic [1:0] RegSkyTemp  = 2'd2;
  localparam logic [1:0] RegSolarIrr = 2'd3;

  typedef struct packed {
    logic [TempW-1:0] temp;
    logic [FracW-1:0] absorb;
    logic [FracW-1:0] expo;
    logic [FracW-1:0] conv_coef;
    logic [FracW-1:0] emis;
    logic [CapW-1:0]  cap;
  } item_t;

  typedef struct packed {
    logic [DtW-1:0]   dt;
    logic [TempW-1:0] air;
    logic [TempW-1:0] sky;
    logic [FracW-1:0] irr;
  } cfg_t;

endpackage

FILE: rtl/surface_temperature_euler_step.sv
// Top level of the surface temperature Euler step with its register port.
//
// Each input beat on in_valid_i/in_ready_o carries one surface element's
// temperature and material properties. Each output beat on
// out_valid_o/out_ready_i carries the element's temperature after one
// explicit Euler step, in the order the elements came in.
// A new element can be accepted in every cycle while the receiver takes
// results, so the sustained rate is one element per clock. A result passes
// through one input register, one queue slot, nine arithmetic stages,
// twenty stages of the bit-per-cycle divider by the heat capacity, and the
// output register.
// When the receiver stalls, the arithmetic pipeline holds in place, the
// queue and the input register fill up, and in_ready_o then falls.
// Reset empties the pipeline and loads the registers with their defaults:
// a 1 s step, 295 K air, 270 K sky and 1000 W/m2 of sunlight.
// Registers are written through the APB port and should change only while
// no element is in flight.
module surface_temperature_euler_step import ste_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [TempW-1:0] temperature_i,
  input  logic [FracW-1:0] solar_absorptivity_i,
  input  logic [FracW-1:0] sun_exposure_i,
  input  logic [FracW-1:0] convection_coefficient_i,
  input  logic [FracW-1:0] emissivity_i,
  input  logic [CapW-1:0]  heat_capacity_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [TempW-1:0] new_temperature_o
);

  logic [DtW-1:0]   dt_q;
  logic [TempW-1:0] air_q, sky_q;
  logic [FracW-1:0] irr_q;
  logic             wr_en;
  cfg_t             cfg;

  logic  fr_valid, fr_ready, bk_valid, bk_ready;
  item_t fr_item, bk_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q  <= 16'd4096;
      air_q <= 18'd18880;
      sky_q <= 18'd17280;
      irr_q <= 16'd16000;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegTimeStep: dt_q  <= pwdata[DtW-1:0];
        RegAirTemp:  air_q <= pwdata[TempW-1:0];
        RegSkyTemp:  sky_q <= pwdata[TempW-1:0];
        RegSolarIrr: irr_q <= pwdata[FracW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegTimeStep: prdata = 32'(dt_q);
      RegAirTemp:  prdata = 32'(air_q);
      RegSkyTemp:  prdata = 32'(sky_q);
      RegSolarIrr: prdata = 32'(irr_q);
      default:     prdata = '0;
    endcase
  end

  assign cfg.dt  = (dt_q > DtMax) ? DtMax : dt_q;
  assign cfg.air = air_q;
  assign cfg.sky = (sky_q < OneKelvin) ? OneKelvin : sky_q;
  assign cfg.irr = irr_q;

  ste_front u_front (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid_i),
    .in_ready_o               (in_ready_o),
    .temperature_i            (temperature_i),
    .solar_absorptivity_i     (solar_absorptivity_i),
    .sun_exposure_i           (sun_exposure_i),
    .convection_coefficient_i (convection_coefficient_i),
    .emissivity_i             (emissivity_i),
    .heat_capacity_i          (heat_capacity_i),
    .item_valid_o             (fr_valid),
    .item_ready_i             (fr_ready),
    .item_o                   (fr_item)
  );

  ste_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (bk_item)
  );

  ste_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .item_valid_i      (bk_valid),
    .item_ready_o      (bk_ready),
    .item_i            (bk_item),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .new_temperature_o (new_temperature_o)
  );

endmodule

FILE: rtl/ste_front.sv
// Input stage that registers an element beat and applies the input clamps.
module ste_front import ste_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [TempW-1:0] temperature_i,
  input  logic [FracW-1:0] solar_absorptivity_i,
  input  logic [FracW-1:0] sun_exposure_i,
  input  logic [FracW-1:0] convection_coefficient_i,
  input  logic [FracW-1:0] emissivity_i,
  input  logic [CapW-1:0]  heat_capacity_i,
  output logic             item_valid_o,
  input  logic             item_ready_i,
  output item_t            item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  assign in_ready_o = !valid_q || item_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    item_d           = item_q;
    valid_d          = valid_q;
    if (item_ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d          = 1'b1;
      item_d.temp      = (temperature_i < OneKelvin) ? OneKelvin : temperature_i;
      item_d.absorb    = solar_absorptivity_i;
      item_d.expo      = sun_exposure_i;
      item_d.conv_coef = convection_coefficient_i;
      item_d.emis      = emissivity_i;
      item_d.cap       = (heat_capacity_i == '0) ? CapW'(1) : heat_capacity_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: rtl/ste_fifo.sv
// Short queue of element items between the front and back parts.
module ste_fifo import ste_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/ste_back.sv
// Arithmetic pipeline that computes the net flux, the step and the new temperature.
module ste_back import ste_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  item_t            item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [TempW-1:0] new_temperature_o
);

  localparam int unsigned PreStages = 9;

  logic adv;
  logic [PreStages-1:0] vld_q, vld_d;

  // Stage 1
  logic [35:0] s1_tt_q, s1_ss_q;
  logic [31:0] s1_ae_q;
  logic signed [18:0] s1_diff_q;
  logic [47:0] s1_es_q;
  logic [FracW-1:0] s1_h_q;
  logic [TempW-1:0] s1_t_q;
  logic [CapW-1:0]  s1_cap_q;
  // Stage 2
  logic [59:0] s2_t4_q, s2_s4_q;
  logic [47:0] s2_solar_q;
  logic signed [35:0] s2_conv_q;
  logic [47:0] s2_es_q;
  logic [TempW-1:0] s2_t_q;
  logic [CapW-1:0]  s2_cap_q;
  // Stage 3
  logic [59:0] s3_dmag_q;
  logic        s3_neg_q;
  logic [61:0] s3_sc_q;
  logic [47:0] s3_es_q;
  logic [TempW-1:0] s3_t_q;
  logic [CapW-1:0]  s3_cap_q;
  // Stage 4
  logic [61:0] s4_p00_q, s4_p01_q;
  logic [45:0] s4_p10_q, s4_p11_q;
  logic        s4_neg_q;
  logic [61:0] s4_sc_q;
  logic [TempW-1:0] s4_t_q;
  logic [CapW-1:0]  s4_cap_q;
  // Stage 5
  logic [59:0] s5_rmag_q;
  logic        s5_neg_q;
  logic [61:0] s5_sc_q;
  logic [TempW-1:0] s5_t_q;
  logic [CapW-1:0]  s5_cap_q;
  // Stage 6
  logic [62:0] s6_flux_q;
  logic [TempW-1:0] s6_t_q;
  logic [CapW-1:0]  s6_cap_q;
  // Stage 7
  logic [61:0] s7_fmag_q;
  logic        s7_fneg_q;
  logic [TempW-1:0] s7_t_q;
  logic [CapW-1:0]  s7_cap_q;
  // Stage 8
  logic [46:0] s8_m0_q, s8_m1_q;
  logic        s8_fneg_q;
  logic [TempW-1:0] s8_t_q;
  logic [CapW-1:0]  s8_cap_q;
  // Stage 9
  logic [CapW-1:0]    s9_rem_q;
  logic [DivBits-1:0] s9_num_q;
  logic        s9_sat_q, s9_fneg_q;
  logic [TempW-1:0] s9_t_q;
  logic [CapW-1:0]  s9_cap_q;
  // Divider stages
  logic [CapW-1:0]    dv_rem_q [DivBits];
  logic [DivBits-1:0] dv_num_q [DivBits];
  logic [DivBits-1:0] dv_quo_q [DivBits];
  logic               dv_sat_q [DivBits];
  logic               dv_neg_q [DivBits];
  logic [TempW-1:0]   dv_t_q   [DivBits];
  logic [CapW-1:0]    dv_cap_q [DivBits];
  logic [DivBits-1:0] dv_vld_q;
  // Output register
  logic             out_vld_q;
  logic [TempW-1:0] out_q, out_d;

  logic [107:0] s5_prod;
  logic [77:0]  s9_prod;
  logic [35:0]  s9_n;
  logic [62:0]  s6_sc_ext;
  logic [DivBits-1:0] fin_q;
  logic signed [20:0] fin_res;

  assign adv          = !out_vld_q || out_ready_i;
  assign item_ready_o = adv;
  assign vld_d        = {vld_q[PreStages-2:0], item_valid_i};

  assign s5_prod = 108'(s4_p00_q) + (108'(s4_p01_q) << 30) + (108'(s4_p10_q) << 32)
                 + (108'(s4_p11_q) << 62);
  assign s6_sc_ext = {s5_sc_q[61], s5_sc_q};
  assign s9_prod = 78'(s8_m0_q) + (78'(s8_m1_q) << 31);
  assign s9_n    = s9_prod[77:42];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_tt_q   <= 36'(item_i.temp) * 36'(item_i.temp);
      s1_ss_q   <= 36'(cfg_i.sky) * 36'(cfg_i.sky);
      s1_ae_q   <= 32'(item_i.absorb) * 32'(item_i.expo);
      s1_diff_q <= $signed({1'b0, cfg_i.air}) - $signed({1'b0, item_i.temp});
      s1_es_q   <= 48'(item_i.emis) * 48'(SigmaQ56);
      s1_h_q    <= item_i.conv_coef;
      s1_t_q    <= item_i.temp;
      s1_cap_q  <= item_i.cap;

      s2_t4_q    <= 60'(s1_tt_q[35:6]) * 60'(s1_tt_q[35:6]);
      s2_s4_q    <= 60'(s1_ss_q[35:6]) * 60'(s1_ss_q[35:6]);
      s2_solar_q <= 48'(s1_ae_q) * 48'(cfg_i.irr);
      s2_conv_q  <= $signed({1'b0, s1_h_q}) * s1_diff_q;
      s2_es_q    <= s1_es_q;
      s2_t_q     <= s1_t_q;
      s2_cap_q   <= s1_cap_q;

      s3_neg_q  <= (s2_t4_q > s2_s4_q);
      s3_dmag_q <= (s2_t4_q > s2_s4_q) ? s2_t4_q - s2_s4_q : s2_s4_q - s2_t4_q;
      s3_sc_q   <= {14'b0, s2_solar_q} + {{2{s2_conv_q[35]}}, s2_conv_q, 24'b0};
      s3_es_q   <= s2_es_q;
      s3_t_q    <= s2_t_q;
      s3_cap_q  <= s2_cap_q;

      s4_p00_q <= 62'(s3_es_q[31:0]) * 62'(s3_dmag_q[29:0]);
      s4_p01_q <= 62'(s3_es_q[31:0]) * 62'(s3_dmag_q[59:30]);
      s4_p10_q <= 46'(s3_es_q[47:32]) * 46'(s3_dmag_q[29:0]);
      s4_p11_q <= 46'(s3_es_q[47:32]) * 46'(s3_dmag_q[59:30]);
      s4_neg_q <= s3_neg_q;
      s4_sc_q  <= s3_sc_q;
      s4_t_q   <= s3_t_q;
      s4_cap_q <= s3_cap_q;

      s5_rmag_q <= s5_prod[107:48];
      s5_neg_q  <= s4_neg_q;
      s5_sc_q   <= s4_sc_q;
      s5_t_q    <= s4_t_q;
      s5_cap_q  <= s4_cap_q;

      s6_flux_q <= s5_neg_q ? s6_sc_ext - 63'(s5_rmag_q) : s6_sc_ext + 63'(s5_rmag_q);
      s6_t_q    <= s5_t_q;
      s6_cap_q  <= s5_cap_q;

      s7_fneg_q <= s6_flux_q[62];
      s7_fmag_q <= s6_flux_q[62] ? 62'(-s6_flux_q) : s6_flux_q[61:0];
      s7_t_q    <= s6_t_q;
      s7_cap_q  <= s6_cap_q;

      s8_m0_q   <= 47'(s7_fmag_q[30:0]) * 47'(cfg_i.dt);
      s8_m1_q   <= 47'(s7_fmag_q[61:31]) * 47'(cfg_i.dt);
      s8_fneg_q <= s7_fneg_q;
      s8_t_q    <= s7_t_q;
      s8_cap_q  <= s7_cap_q;

      s9_rem_q  <= CapW'(s9_n[35:20]);
      s9_num_q  <= s9_n[19:0];
      s9_sat_q  <= (CapW'(s9_n[35:20]) >= s8_cap_q);
      s9_fneg_q <= s8_fneg_q;
      s9_t_q    <= s8_t_q;
      s9_cap_q  <= s8_cap_q;
    end
  end

  for (genvar k = 0; k < DivBits; k++) begin : g_div
    logic [CapW-1:0]    src_rem;
    logic [DivBits-1:0] src_num, src_quo;
    logic               src_sat, src_neg, src_vld;
    logic [TempW-1:0]   src_t;
    logic [CapW-1:0]    src_cap;
    logic [CapW:0]      trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign src_rem = s9_rem_q;
      assign src_num = s9_num_q;
      assign src_quo = '0;
      assign src_sat = s9_sat_q;
      assign src_neg = s9_fneg_q;
      assign src_t   = s9_t_q;
      assign src_cap = s9_cap_q;
      assign src_vld = vld_q[PreStages-1];
    end else begin : g_next
      assign src_rem = dv_rem_q[k-1];
      assign src_num = dv_num_q[k-1];
      assign src_quo = dv_quo_q[k-1];
      assign src_sat = dv_sat_q[k-1];
      assign src_neg = dv_neg_q[k-1];
      assign src_t   = dv_t_q[k-1];
      assign src_cap = dv_cap_q[k-1];
      assign src_vld = dv_vld_q[k-1];
    end

    assign trial = {src_rem, src_num[DivBits-1]};
    assign ge    = (trial >= {1'b0, src_cap});

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[k] <= ge ? CapW'(trial - {1'b0, src_cap}) : trial[CapW-1:0];
        dv_num_q[k] <= {src_num[DivBits-2:0], 1'b0};
        dv_quo_q[k] <= {src_quo[DivBits-2:0], ge};
        dv_sat_q[k] <= src_sat;
        dv_neg_q[k] <= src_neg;
        dv_t_q[k]   <= src_t;
        dv_cap_q[k] <= src_cap;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[k] <= src_vld;
      end
    end
  end

  always_comb begin
    if (dv_sat_q[DivBits-1] || dv_quo_q[DivBits-1] > QuoMax) begin
      fin_q = QuoMax;
    end else begin
      fin_q = dv_quo_q[DivBits-1];
    end
    if (dv_neg_q[DivBits-1]) begin
      fin_res = $signed({3'b0, dv_t_q[DivBits-1]}) - $signed({1'b0, fin_q});
    end else begin
      fin_res = $signed({3'b0, dv_t_q[DivBits-1]}) + $signed({1'b0, fin_q});
    end
    if (fin_res < $signed({3'b0, OneKelvin})) begin
      out_d = OneKelvin;
    end else if (fin_res > $signed({3'b0, TempMax})) begin
      out_d = TempMax;
    end else begin
      out_d = fin_res[TempW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= vld_d;
      out_vld_q <= dv_vld_q[DivBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign new_temperature_o = out_q;

endmodule
